FILE: sv/icmpf_pkg.sv
// ----------------------------------------------------------------------------
// icmpf_pkg
// Types, constants and the FNV-1a step shared by the ICMP echo filter.
// ----------------------------------------------------------------------------
package icmpf_pkg;

  localparam logic [63:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;

  localparam int unsigned MinPacketBytes = 28;
  localparam int unsigned MaxPacketBytes = 65535;
  localparam int unsigned MinHeaderBytes = 20;
  localparam int unsigned EchoHeaderBytes = 8;

  localparam logic [3:0] IpVersion4 = 4'd4;
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] IcmpEchoRequest = 8'd8;
  localparam logic [7:0] IcmpCodeZero = 8'd0;
  localparam logic [7:0] FlagsMask = 8'hbf;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [CfgIndexWidth-1:0] RegSrcAddr = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegDstAddr = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegIdentMin = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegIdentMax = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegSeqMin = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegSeqMax = 3'd5;

  localparam logic [31:0] SrcAddrReset = 32'd170721282;
  localparam logic [31:0] DstAddrReset = 32'd170721281;
  localparam logic [15:0] IdentMinReset = 16'd10001;
  localparam logic [15:0] IdentMaxReset = 16'd10099;
  localparam logic [15:0] SeqMinReset = 16'd1;
  localparam logic [15:0] SeqMaxReset = 16'd5;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ident_min;
    logic [15:0] ident_max;
    logic [15:0] seq_min;
    logic [15:0] seq_max;
  } cfg_t;

  typedef struct packed {
    logic adv;
    logic fin;
  } step_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] ip_ident;
    logic [15:0] echo_ident;
    logic [15:0] echo_sequence;
    logic [15:0] byte_count;
  } verdict_t;

  // The prime 2^40 + 0x1b3 reduces to a sum of shifted copies.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [7:0] addr_byte(input logic [31:0] addr, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = addr[31:24];
      2'd1: r = addr[23:16];
      2'd2: r = addr[15:8];
      default: r = addr[7:0];
    endcase
    return r;
  endfunction

endpackage

FILE: sv/icmpf_hash.sv
// ----------------------------------------------------------------------------
// icmpf_hash
// Running FNV-1a 64-bit accumulator; one byte folded in per processed beat.
// ----------------------------------------------------------------------------
module icmpf_hash (
  input  logic               clk,
  input  logic               rst,
  input  icmpf_pkg::step_t   step,
  input  logic [7:0]         data_byte,
  output logic [63:0]        hash_now
);
  import icmpf_pkg::*;

  logic [63:0] hash;

  assign hash_now = fnv_step(hash, data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= FnvBasis;
    end else if (step.adv) begin
      hash <= step.fin ? FnvBasis : hash_now;
    end
  end

endmodule

FILE: sv/icmpf_parser.sv
// ----------------------------------------------------------------------------
// icmpf_parser
// Tracks the byte position, captures IPv4 and ICMP header fields, runs the
// per-byte checks and forms the verdict on the final byte.
// ----------------------------------------------------------------------------
module icmpf_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  icmpf_pkg::step_t     step,
  input  logic [7:0]           data_byte,
  input  icmpf_pkg::cfg_t      cfg,
  output icmpf_pkg::verdict_t  verdict
);
  import icmpf_pkg::*;

  logic [16:0] bytes_seen;
  logic [5:0]  header_bytes;
  logic [15:0] length_field;
  logic [15:0] ident_field;
  logic [15:0] echo_id_field;
  logic [15:0] echo_seq_field;
  logic        checks_ok;

  logic [16:0] bytes_seen_next;
  logic [5:0]  header_bytes_next;
  logic [15:0] length_field_next;
  logic [15:0] ident_field_next;
  logic [15:0] echo_id_field_next;
  logic [15:0] echo_seq_field_next;
  logic        checks_ok_next;

  logic [16:0] rel;
  logic        in_echo;
  logic        ok;

  always_comb begin
    bytes_seen_next = bytes_seen;
    header_bytes_next = header_bytes;
    length_field_next = length_field;
    ident_field_next = ident_field;
    echo_id_field_next = echo_id_field;
    echo_seq_field_next = echo_seq_field;
    checks_ok_next = checks_ok;
    rel = bytes_seen - {11'd0, header_bytes};
    in_echo = (header_bytes >= 6'(MinHeaderBytes)) &&
              (bytes_seen >= {11'd0, header_bytes}) && (rel[16:3] == '0);

    if (!bytes_seen[16]) begin
      if (bytes_seen == 17'd0) begin
        header_bytes_next = {data_byte[3:0], 2'b00};
        if (data_byte[7:4] != IpVersion4) checks_ok_next = 1'b0;
        if ({data_byte[3:0], 2'b00} < 6'(MinHeaderBytes)) checks_ok_next = 1'b0;
      end else if (bytes_seen == 17'd2 || bytes_seen == 17'd3) begin
        length_field_next = {length_field[7:0], data_byte};
      end else if (bytes_seen == 17'd4 || bytes_seen == 17'd5) begin
        ident_field_next = {ident_field[7:0], data_byte};
      end else if (bytes_seen == 17'd6) begin
        if ((data_byte & FlagsMask) != 8'd0) checks_ok_next = 1'b0;
      end else if (bytes_seen == 17'd7) begin
        if (data_byte != 8'd0) checks_ok_next = 1'b0;
      end else if (bytes_seen == 17'd9) begin
        if (data_byte != ProtoIcmp) checks_ok_next = 1'b0;
      end else if (bytes_seen >= 17'd12 && bytes_seen <= 17'd15) begin
        if (addr_byte(cfg.src_addr, bytes_seen[1:0]) != data_byte) checks_ok_next = 1'b0;
      end else if (bytes_seen >= 17'd16 && bytes_seen <= 17'd19) begin
        if (addr_byte(cfg.dst_addr, bytes_seen[1:0]) != data_byte) checks_ok_next = 1'b0;
      end

      if (in_echo) begin
        case (rel[2:0])
          3'd0: if (data_byte != IcmpEchoRequest) checks_ok_next = 1'b0;
          3'd1: if (data_byte != IcmpCodeZero) checks_ok_next = 1'b0;
          3'd4, 3'd5: echo_id_field_next = {echo_id_field[7:0], data_byte};
          3'd6, 3'd7: echo_seq_field_next = {echo_seq_field[7:0], data_byte};
          default: ;
        endcase
      end
      bytes_seen_next = bytes_seen + 17'd1;
    end

    ok = checks_ok_next &&
         (bytes_seen_next >= 17'(MinPacketBytes)) &&
         (bytes_seen_next <= 17'(MaxPacketBytes)) &&
         ({11'd0, header_bytes_next} + 17'(EchoHeaderBytes) <= bytes_seen_next) &&
         ({1'b0, length_field_next} == bytes_seen_next) &&
         (echo_id_field_next >= cfg.ident_min) && (echo_id_field_next <= cfg.ident_max) &&
         (echo_seq_field_next >= cfg.seq_min) && (echo_seq_field_next <= cfg.seq_max);

    verdict.accepted = ok;
    verdict.ip_ident = ok ? ident_field_next : 16'd0;
    verdict.echo_ident = ok ? echo_id_field_next : 16'd0;
    verdict.echo_sequence = ok ? echo_seq_field_next : 16'd0;
    verdict.byte_count = ok ? bytes_seen_next[15:0] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step.adv && step.fin)) begin
      bytes_seen <= '0;
      header_bytes <= '0;
      length_field <= '0;
      ident_field <= '0;
      echo_id_field <= '0;
      echo_seq_field <= '0;
      checks_ok <= 1'b1;
    end else if (step.adv) begin
      bytes_seen <= bytes_seen_next;
      header_bytes <= header_bytes_next;
      length_field <= length_field_next;
      ident_field <= ident_field_next;
      echo_id_field <= echo_id_field_next;
      echo_seq_field <= echo_seq_field_next;
      checks_ok <= checks_ok_next;
    end
  end

endmodule

FILE: sv/icmp_echo_filter_fingerprint.sv
// ----------------------------------------------------------------------------
// icmp_echo_filter_fingerprint
// ICMP echo request filter for IPv4 packets with an FNV-1a 64-bit fingerprint.
// ----------------------------------------------------------------------------
// The slave stream carries one packet byte per beat in s_axis_tdata, with
// s_axis_tlast on the final byte. The master stream gives one result beat per
// packet: m_axis_tuser is the verdict and m_axis_tdata holds the IP
// identification, echo identifier, echo sequence, byte count and fingerprint.
// All payload fields of a rejected packet are zero.
// The block takes one byte per cycle. A byte is held in the input register
// and is then folded into the header state and the hash; when the final byte
// is folded in, the result beat is written to the output register. The hash
// update, a combinational sum of shifted copies, sets the cycle time.
// When the receiver stalls, the result waits in the output register while
// bytes of the next packet keep flowing; only its final byte waits for the
// output register to free up, and then s_axis_tready drops. Reset restores
// the default addresses and ranges, clears the packet state and empties both
// registers. The cfg_* port writes one register per cycle; the user must use
// it only while no packet is in progress, and the block does not enforce it.
// ----------------------------------------------------------------------------
module icmp_echo_filter_fingerprint (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // data_byte
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // ip_ident, echo_ident, echo_sequence, byte_count, fingerprint
  output logic [127:0]                         m_axis_tdata,
  output logic                                 m_axis_tuser,  // accepted
  input  logic                                 cfg_we,
  input  logic [icmpf_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [icmpf_pkg::CfgDataWidth-1:0]   cfg_data
);
  import icmpf_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  logic [7:0]  in_data;
  logic        in_last;
  step_t       step;
  verdict_t    verdict;
  logic [63:0] hash_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_addr <= SrcAddrReset;
      cfg.dst_addr <= DstAddrReset;
      cfg.ident_min <= IdentMinReset;
      cfg.ident_max <= IdentMaxReset;
      cfg.seq_min <= SeqMinReset;
      cfg.seq_max <= SeqMaxReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSrcAddr: cfg.src_addr <= cfg_data;
        RegDstAddr: cfg.dst_addr <= cfg_data;
        RegIdentMin: cfg.ident_min <= cfg_data[15:0];
        RegIdentMax: cfg.ident_max <= cfg_data[15:0];
        RegSeqMin: cfg.seq_min <= cfg_data[15:0];
        RegSeqMax: cfg.seq_max <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign step = '{adv: in_valid && (!in_last || !m_axis_tvalid || m_axis_tready),
                  fin: in_last};
  assign s_axis_tready = !in_valid || step.adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step.adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  icmpf_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_data),
    .hash_now  (hash_now)
  );

  icmpf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_data),
    .cfg       (cfg),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step.adv && step.fin) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.adv && step.fin) begin
      m_axis_tuser <= verdict.accepted;
      m_axis_tdata <= {verdict.accepted ? hash_now : 64'd0, verdict.byte_count,
                       verdict.echo_sequence, verdict.echo_ident, verdict.ip_ident};
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 128'd0)
    else $error("rejected result carries nonzero payload");

  a_accept_size: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:48] >= 16'(MinPacketBytes))
    else $error("accepted result with too few bytes");

  a_final_result: assert property (@(posedge clk) disable iff (rst)
    step.adv && step.fin |=> m_axis_tvalid)
    else $error("final byte processed without a result");

endmodule

FILE: sim/icmp_echo_filter_checker.sv
// ----------------------------------------------------------------------------
// icmp_echo_filter_checker
// Watches both streams and the register port of the ICMP echo filter, runs its
// own model of the header checks and the FNV-1a fingerprint over every byte
// beat, and compares each result beat field by field with the oldest verdict
// still waiting.
// ----------------------------------------------------------------------------
module icmp_echo_filter_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,
  input  logic                                s_axis_tlast,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [127:0]                        m_axis_tdata,
  input  logic                                m_axis_tuser,
  input  logic                                cfg_we,
  input  logic [icmpf_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [icmpf_pkg::CfgDataWidth-1:0]  cfg_data,
  output int                                  mismatches,
  output int                                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import icmpf_pkg::*;

  localparam logic [63:0] FnvPrime = 64'd1099511628211;
  localparam logic [16:0] CountCeiling = 17'd65536;

  typedef struct packed {
    logic        accepted;
    logic [15:0] ip_id;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic [15:0] length;
    logic [63:0] hash;
  } echo_verdict_t;

  cfg_t          settings;
  logic [16:0]   byte_pos;
  logic [63:0]   hash_acc;
  logic [5:0]    hdr_len;
  logic [15:0]   total_len;
  logic [15:0]   ip_id;
  logic [15:0]   echo_id;
  logic [15:0]   echo_seq;
  logic          all_ok;
  echo_verdict_t verdicts_q[$];
  int            fail_count = 0;
  int            result_no = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("result %0d: %s is %h, expected %h", result_no, what, got, want);
    fail_count++;
  endtask

  task automatic clear_packet();
    byte_pos = '0;
    hash_acc = FnvBasis;
    hdr_len = '0;
    total_len = '0;
    ip_id = '0;
    echo_id = '0;
    echo_seq = '0;
    all_ok = 1'b1;
  endtask

  task automatic fold_byte(input logic [7:0] b, input logic fin);
    int            pos;
    int            rel;
    logic [31:0]   addr_w;
    logic [16:0]   size;
    echo_verdict_t v;
    pos = byte_pos;
    hash_acc = (hash_acc ^ {56'd0, b}) * FnvPrime;
    if (byte_pos != CountCeiling) begin
      case (pos)
        0: begin
          if (b[7:4] != IpVersion4) all_ok = 1'b0;
          hdr_len = {b[3:0], 2'b00};
          if (hdr_len < MinHeaderBytes) all_ok = 1'b0;
        end
        2, 3: total_len = {total_len[7:0], b};
        4, 5: ip_id = {ip_id[7:0], b};
        6: if ((b & FlagsMask) != 8'd0) all_ok = 1'b0;
        7: if (b != 8'd0) all_ok = 1'b0;
        9: if (b != ProtoIcmp) all_ok = 1'b0;
        12, 13, 14, 15: begin
          addr_w = settings.src_addr >> (8 * (15 - pos));
          if (addr_w[7:0] != b) all_ok = 1'b0;
        end
        16, 17, 18, 19: begin
          addr_w = settings.dst_addr >> (8 * (19 - pos));
          if (addr_w[7:0] != b) all_ok = 1'b0;
        end
        default: ;
      endcase
      if (hdr_len >= MinHeaderBytes && pos >= hdr_len) begin
        rel = pos - hdr_len;
        case (rel)
          0: if (b != IcmpEchoRequest) all_ok = 1'b0;
          1: if (b != IcmpCodeZero) all_ok = 1'b0;
          4, 5: echo_id = {echo_id[7:0], b};
          6, 7: echo_seq = {echo_seq[7:0], b};
          default: ;
        endcase
      end
      byte_pos = byte_pos + 17'd1;
    end
    if (fin) begin
      size = byte_pos;
      v = '0;
      if (all_ok && size >= MinPacketBytes && size <= MaxPacketBytes &&
          hdr_len + EchoHeaderBytes <= size && total_len == size &&
          echo_id >= settings.ident_min && echo_id <= settings.ident_max &&
          echo_seq >= settings.seq_min && echo_seq <= settings.seq_max) begin
        v.accepted = 1'b1;
        v.ip_id = ip_id;
        v.echo_id = echo_id;
        v.echo_seq = echo_seq;
        v.length = size[15:0];
        v.hash = hash_acc;
      end
      verdicts_q.push_back(v);
      clear_packet();
    end
  endtask

  task automatic check_result();
    echo_verdict_t want;
    if (verdicts_q.size() == 0) begin
      report_mismatch("unexpected result beat", {63'd0, m_axis_tuser}, 64'd0);
    end else begin
      want = verdicts_q.pop_front();
      if (m_axis_tuser !== want.accepted)
        report_mismatch("accepted", {63'd0, m_axis_tuser}, {63'd0, want.accepted});
      if (m_axis_tdata[15:0] !== want.ip_id)
        report_mismatch("ip_ident", {48'd0, m_axis_tdata[15:0]}, {48'd0, want.ip_id});
      if (m_axis_tdata[31:16] !== want.echo_id)
        report_mismatch("echo_ident", {48'd0, m_axis_tdata[31:16]}, {48'd0, want.echo_id});
      if (m_axis_tdata[47:32] !== want.echo_seq)
        report_mismatch("echo_sequence", {48'd0, m_axis_tdata[47:32]},
                        {48'd0, want.echo_seq});
      if (m_axis_tdata[63:48] !== want.length)
        report_mismatch("byte_count", {48'd0, m_axis_tdata[63:48]}, {48'd0, want.length});
      if (m_axis_tdata[127:64] !== want.hash)
        report_mismatch("fingerprint", m_axis_tdata[127:64], want.hash);
    end
    result_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      settings.src_addr = SrcAddrReset;
      settings.dst_addr = DstAddrReset;
      settings.ident_min = IdentMinReset;
      settings.ident_max = IdentMaxReset;
      settings.seq_min = SeqMinReset;
      settings.seq_max = SeqMaxReset;
      clear_packet();
      verdicts_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_we) begin
        case (cfg_index)
          RegSrcAddr: settings.src_addr = cfg_data;
          RegDstAddr: settings.dst_addr = cfg_data;
          RegIdentMin: settings.ident_min = cfg_data[15:0];
          RegIdentMax: settings.ident_max = cfg_data[15:0];
          RegSeqMin: settings.seq_min = cfg_data[15:0];
          RegSeqMax: settings.seq_max = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) fold_byte(s_axis_tdata, s_axis_tlast);
    end
    outstanding <= verdicts_q.size();
    mismatches <= fail_count;
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the ICMP echo filter: directed packets at the range edges and
// for several header checks, the largest and an overlong packet, then random
// echo requests with random flaws under several register settings, with random
// idling on both streams, a long receiver hold-off and a burst without gaps.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import icmpf_pkg::*;

  localparam int HoldCycles = 400;
  localparam int CycleLimit = 1_000_000;
  localparam int RandomBytes = 1850;
  localparam logic [CfgIndexWidth-1:0] RegSpare = 3'd7;

  localparam int FlawVersion = 0;
  localparam int FlawHeaderLen = 1;
  localparam int FlawLength = 2;
  localparam int FlawFlags = 3;
  localparam int FlawOffset = 4;
  localparam int FlawProto = 5;
  localparam int FlawSource = 6;
  localparam int FlawDest = 7;
  localparam int FlawType = 8;
  localparam int FlawCode = 9;
  localparam int FlawIdent = 10;
  localparam int FlawSeq = 11;
  localparam int FlawShort = 12;
  localparam int FlawTail = 13;
  localparam int FlawNoise = 14;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata = 8'd0;
  logic                     s_axis_tlast = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [127:0]             m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;
  int                       mismatches;
  int                       outstanding;

  logic        calm = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          sent_bytes = 0;
  logic [7:0]  frame[$];
  logic [31:0] want_src = SrcAddrReset;
  logic [31:0] want_dst = DstAddrReset;
  logic [15:0] id_lo = IdentMinReset;
  logic [15:0] id_hi = IdentMaxReset;
  logic [15:0] seq_lo = SeqMinReset;
  logic [15:0] seq_hi = SeqMaxReset;

  icmp_echo_filter_fingerprint dut (.*);
  icmp_echo_filter_checker verdict_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 24);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_beat(frame[i], i == frame.size() - 1);
    sent_bytes += frame.size();
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic poke(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] src, input logic [31:0] dst,
                               input logic [15:0] imin, input logic [15:0] imax,
                               input logic [15:0] smin, input logic [15:0] smax);
    poke(RegSrcAddr, src);
    poke(RegDstAddr, dst);
    poke(RegIdentMin, ($urandom << 16) | imin);
    poke(RegIdentMax, ($urandom << 16) | imax);
    poke(RegSeqMin, ($urandom << 16) | smin);
    poke(RegSeqMax, ($urandom << 16) | smax);
    poke(RegSpare, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
    want_src = src;
    want_dst = dst;
    id_lo = imin;
    id_hi = imax;
    seq_lo = smin;
    seq_hi = smax;
  endtask

  function automatic logic [15:0] pick_in(input logic [15:0] lo, input logic [15:0] hi);
    if (lo <= hi) return $urandom_range(hi, lo);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_out(input logic [15:0] lo, input logic [15:0] hi);
    if (lo > 0 && (hi == 16'hffff || $urandom_range(1) == 0))
      return $urandom_range(lo - 1, 0);
    if (hi != 16'hffff) return $urandom_range(16'hffff, hi + 1);
    return $urandom;
  endfunction

  task automatic set_length(input int n);
    frame[2] = n >> 8;
    frame[3] = n;
  endtask

  task automatic build_echo(input logic [3:0] ihl, input int payload,
                            input logic [15:0] eid, input logic [15:0] eseq);
    int hb;
    hb = ihl * 4;
    frame.delete();
    frame.push_back({IpVersion4, ihl});
    frame.push_back($urandom);
    frame.push_back(8'd0);
    frame.push_back(8'd0);
    frame.push_back($urandom);
    frame.push_back($urandom);
    frame.push_back($urandom_range(1) ? 8'h40 : 8'h00);
    frame.push_back(8'd0);
    frame.push_back($urandom);
    frame.push_back(ProtoIcmp);
    frame.push_back($urandom);
    frame.push_back($urandom);
    for (int i = 3; i >= 0; i--) frame.push_back(want_src >> (8 * i));
    for (int i = 3; i >= 0; i--) frame.push_back(want_dst >> (8 * i));
    if (hb > MinHeaderBytes) repeat (hb - MinHeaderBytes) frame.push_back($urandom);
    frame.push_back(IcmpEchoRequest);
    frame.push_back(IcmpCodeZero);
    frame.push_back($urandom);
    frame.push_back($urandom);
    frame.push_back(eid[15:8]);
    frame.push_back(eid[7:0]);
    frame.push_back(eseq[15:8]);
    frame.push_back(eseq[7:0]);
    repeat (payload) frame.push_back($urandom);
    set_length(frame.size());
  endtask

  task automatic spoil(input int flaw);
    int          hb;
    int          n;
    logic [7:0]  t;
    logic [7:0]  nz;
    logic [15:0] v;
    t = frame[0];
    hb = t[3:0] * 4;
    nz = $urandom_range(255, 1);
    case (flaw)
      FlawVersion: begin
        n = $urandom_range(14);
        t[7:4] = (n >= 4) ? n + 1 : n;
        frame[0] = t;
      end
      FlawHeaderLen: begin
        t[3:0] = $urandom_range(4);
        frame[0] = t;
      end
      FlawLength: set_length({frame[2], frame[3]} ^ $urandom_range(65535, 1));
      FlawFlags: begin
        n = $urandom_range(6);
        if (n == 6) n = 7;
        t = frame[6];
        t[n] = 1'b1;
        frame[6] = t;
      end
      FlawOffset: frame[7] = nz;
      FlawProto: frame[9] = frame[9] ^ nz;
      FlawSource: begin
        n = 12 + $urandom_range(3);
        frame[n] = frame[n] ^ nz;
      end
      FlawDest: begin
        n = 16 + $urandom_range(3);
        frame[n] = frame[n] ^ nz;
      end
      FlawType: frame[hb] = frame[hb] ^ nz;
      FlawCode: frame[hb + 1] = frame[hb + 1] ^ nz;
      FlawIdent: begin
        v = pick_out(id_lo, id_hi);
        frame[hb + 4] = v[15:8];
        frame[hb + 5] = v[7:0];
      end
      FlawSeq: begin
        v = pick_out(seq_lo, seq_hi);
        frame[hb + 6] = v[15:8];
        frame[hb + 7] = v[7:0];
      end
      FlawShort: begin
        n = $urandom_range(hb + 7, 1);
        while (frame.size() > n) t = frame.pop_back();
        if (n >= 4) set_length(n);
      end
      FlawTail: repeat ($urandom_range(4, 1)) frame.push_back($urandom);
      default: begin
        frame.delete();
        repeat ($urandom_range(60, 1)) frame.push_back($urandom);
      end
    endcase
  endtask

  initial begin
    logic [7:0]  t;
    logic [3:0]  ihl;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    int          payload;
    int          goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: range edges and several header checks in turn.
    build_echo(4'd5, 0, IdentMinReset, SeqMinReset);
    send_frame();
    build_echo(4'd15, 6, IdentMaxReset, SeqMaxReset);
    frame[frame.size() - 2] = 8'h00;
    frame[frame.size() - 1] = 8'hff;
    send_frame();
    build_echo(4'd5, 3, IdentMinReset - 16'd1, SeqMinReset);
    send_frame();
    build_echo(4'd5, 3, IdentMaxReset, SeqMaxReset + 16'd1);
    send_frame();
    build_echo(4'd5, 0, IdentMinReset, SeqMaxReset);
    spoil(FlawVersion);
    send_frame();
    build_echo(4'd5, 0, IdentMinReset, SeqMaxReset);
    t = frame[0];
    t[3:0] = 4'd0;
    frame[0] = t;
    send_frame();
    build_echo(4'd5, 0, IdentMinReset, SeqMinReset);
    t = frame.pop_back();
    set_length(frame.size());
    send_frame();
    build_echo(4'd15, 0, IdentMinReset, SeqMinReset);
    while (frame.size() > 40) t = frame.pop_back();
    set_length(40);
    send_frame();
    build_echo(4'd5, 2, IdentMaxReset, SeqMinReset);
    frame[6] = 8'h40;
    send_frame();
    build_echo(4'd5, 2, IdentMaxReset, SeqMinReset);
    frame[6] = 8'h20;
    send_frame();
    frame.delete();
    frame.push_back(8'h45);
    send_frame();
    settle();

    // Empty ranges reject everything.
    load_settings(SrcAddrReset, DstAddrReset, 16'd200, 16'd100, 16'd9, 16'd8);
    build_echo(4'd5, 0, 16'd150, 16'd8);
    send_frame();
    settle();

    // Full ranges, extreme identifiers, the largest and an overlong packet.
    load_settings(32'h0000_0000, 32'hffff_ffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff);
    build_echo(4'd5, 1, 16'h0000, 16'h0000);
    send_frame();
    build_echo(4'd5, 1, 16'hffff, 16'hffff);
    send_frame();
    build_echo(4'd5, MaxPacketBytes - MinPacketBytes, 16'h1234, 16'hfedc);
    send_frame();
    build_echo(4'd5, MaxPacketBytes - MinPacketBytes + 2, 16'h1234, 16'hfedc);
    send_frame();
    settle();

    // The receiver holds off while short packets arrive back to back.
    hold_go <= ~hold_go;
    calm <= 1'b1;
    repeat (6) begin
      build_echo(4'd5, $urandom_range(8), pick_in(id_lo, id_hi), pick_in(seq_lo, seq_hi));
      send_frame();
    end
    calm <= 1'b0;
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_settings(SrcAddrReset, DstAddrReset, IdentMinReset, IdentMaxReset,
                         SeqMinReset, SeqMaxReset);
        1: load_settings(32'h0000_0000, 32'hffff_ffff, 16'h0000, 16'hffff,
                         16'h0000, 16'hffff);
        2: begin
          a = $urandom;
          b = $urandom;
          c = $urandom;
          d = $urandom;
          load_settings($urandom, $urandom, (a < b) ? a : b, (a < b) ? b : a,
                        (c < d) ? c : d, (c < d) ? d : c);
        end
        default: load_settings(32'hffff_ffff, 32'h0000_0000, 16'hffff, 16'hffff,
                               16'h0000, 16'h0000);
      endcase
      calm <= (ph == 1);
      goal = sent_bytes + RandomBytes / 4;
      while (sent_bytes < goal) begin
        ihl = ($urandom_range(9) < 7) ? 4'd5 : $urandom_range(15, 6);
        payload = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(24);
        build_echo(ihl, payload, pick_in(id_lo, id_hi), pick_in(seq_lo, seq_hi));
        if ($urandom_range(99) >= 55) spoil($urandom_range(FlawNoise, FlawVersion));
        send_frame();
      end
      calm <= 1'b0;
      settle();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
